// ===== src/sitdc_pkg.sv =====
package sitdc_pkg;

	localparam int BIN_BITS   = 16;
	localparam int BUF_DIGITS = 5;
	localparam int BCD_BITS   = 4 * BUF_DIGITS;

	localparam logic [6:0] DIGIT_BASE = 7'd48;
	localparam logic [6:0] DOT_CODE   = 7'd46;
	localparam logic [6:0] MINUS_CODE = 7'd45;
	localparam logic [6:0] PLUS_CODE  = 7'd43;

	localparam logic signed [3:0] AUTO_WIDTH = 4'sb1111;

	typedef struct packed {
		logic signed [15:0] number;
		logic signed [3:0]  field_width;
		logic [1:0]         decimal_places;
		logic               force_plus;
	} arg_req_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic       last_char;
	} chr_req_t;

	typedef struct packed {
		logic              negative;
		logic              force_plus;
		logic signed [3:0] field_width;
		logic [1:0]        decimal_places;
	} fmt_t;

endpackage

// ===== src/sitdc_dabble.sv =====
module sitdc_dabble (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [sitdc_pkg::BIN_BITS-1:0]  mag,
	output logic                            done,
	output logic [sitdc_pkg::BCD_BITS-1:0]  bcd
);

	logic [sitdc_pkg::BIN_BITS-1:0] bin_q;
	logic [sitdc_pkg::BCD_BITS-1:0] bcd_q;
	logic [sitdc_pkg::BCD_BITS-1:0] adj;
	logic [4:0]                     cnt_q;
	logic                           busy_q;
	logic                           done_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int j = 0; j < sitdc_pkg::BUF_DIGITS; j++) begin
			adj[4*j +: 4] = (bcd_q[4*j +: 4] >= 4'd5) ? bcd_q[4*j +: 4] + 4'd3
				: bcd_q[4*j +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(sitdc_pkg::BIN_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[sitdc_pkg::BCD_BITS-2:0], bin_q[sitdc_pkg::BIN_BITS-1]};
			bin_q <= {bin_q[sitdc_pkg::BIN_BITS-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ===== src/sitdc_emit.sv =====
module sitdc_emit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  sitdc_pkg::fmt_t                fmt,
	input  logic [sitdc_pkg::BCD_BITS-1:0] bcd,
	output logic                           busy,
	output logic                           chr_valid,
	input  logic                           chr_ready,
	output sitdc_pkg::chr_req_t            chr
);

	localparam logic [1:0] PH_SIGN = 2'd0;
	localparam logic [1:0] PH_INT  = 2'd1;
	localparam logic [1:0] PH_DOT  = 2'd2;
	localparam logic [1:0] PH_FRAC = 2'd3;

	logic [sitdc_pkg::BCD_BITS-1:0] digits_q;
	logic                           neg_q;
	logic                           has_int_q;
	logic                           has_dot_q;
	logic [2:0]                     end_q;
	logic [2:0]                     k_q;
	logic [1:0]                     phase_q;
	logic                           busy_q;
	logic                           out_valid_q;
	sitdc_pkg::chr_req_t            out_q;

	logic [2:0] start_v;
	logic [2:0] end_v;
	logic       has_sign_v;
	logic       has_int_v;
	logic       has_dot_v;
	logic [3:0] dig;
	logic [6:0] cur_char;
	logic       cur_last;
	logic [1:0] nxt_phase;
	logic [2:0] nxt_k;
	logic       out_free;

	// start and end positions of the integer digits, and which of sign, integer digits and dot are present
	always_comb begin
		if (fmt.field_width == sitdc_pkg::AUTO_WIDTH) begin
			if (bcd[19:16] != 4'd0)      start_v = 3'd0;
			else if (bcd[15:12] != 4'd0) start_v = 3'd1;
			else if (bcd[11:8] != 4'd0)  start_v = 3'd2;
			else if (bcd[7:4] != 4'd0)   start_v = 3'd3;
			else                         start_v = 3'd4;
		end else if (fmt.field_width[3]) begin
			start_v = 3'd5;
		end else if (fmt.field_width >= 4'sd5) begin
			start_v = 3'd0;
		end else begin
			start_v = 3'd5 - 3'(fmt.field_width);
		end
		case (fmt.decimal_places)
			2'd0:    end_v = 3'd5;
			2'd1:    end_v = 3'd4;
			default: end_v = 3'd3;
		endcase
		has_sign_v = fmt.negative || fmt.force_plus;
		has_int_v  = start_v < end_v;
		has_dot_v  = fmt.decimal_places != 2'd0;
	end

	always_comb begin
		unique case (k_q)
			3'd0:    dig = digits_q[19:16];
			3'd1:    dig = digits_q[15:12];
			3'd2:    dig = digits_q[11:8];
			3'd3:    dig = digits_q[7:4];
			3'd4:    dig = digits_q[3:0];
			default: dig = 4'd0;
		endcase
	end

	always_comb begin
		cur_char  = sitdc_pkg::DIGIT_BASE + {3'd0, dig};
		cur_last  = 1'b0;
		nxt_phase = phase_q;
		nxt_k     = k_q;
		unique case (phase_q)
			PH_SIGN: begin
				cur_char  = neg_q ? sitdc_pkg::MINUS_CODE : sitdc_pkg::PLUS_CODE;
				cur_last  = !has_int_q && !has_dot_q;
				nxt_phase = has_int_q ? PH_INT : PH_DOT;
			end
			PH_INT: begin
				cur_last  = (k_q == end_q - 3'd1) && !has_dot_q;
				nxt_phase = (k_q == end_q - 3'd1) ? PH_DOT : PH_INT;
				nxt_k     = k_q + 3'd1;
			end
			PH_DOT: begin
				cur_char  = sitdc_pkg::DOT_CODE;
				nxt_phase = PH_FRAC;
				nxt_k     = end_q;
			end
			PH_FRAC: begin
				cur_last = k_q == 3'd4;
				nxt_k    = k_q + 3'd1;
			end
			default: ;
		endcase
	end

	assign out_free = !out_valid_q || chr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_SIGN;
			k_q         <= '0;
		end else begin
			if (busy_q && out_free && !load)
				out_valid_q <= 1'b1;
			else if (chr_ready)
				out_valid_q <= 1'b0;
			if (load) begin
				busy_q <= has_sign_v || has_int_v || has_dot_v;
				k_q    <= start_v;
				if (has_sign_v)     phase_q <= PH_SIGN;
				else if (has_int_v) phase_q <= PH_INT;
				else                phase_q <= PH_DOT;
			end else if (busy_q && out_free) begin
				phase_q     <= nxt_phase;
				k_q         <= nxt_k;
				busy_q      <= !cur_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q  <= bcd;
			neg_q     <= fmt.negative;
			has_int_q <= has_int_v;
			has_dot_q <= has_dot_v;
			end_q     <= end_v;
		end
		if (!load && busy_q && out_free) begin
			out_q.char_code <= cur_char;
			out_q.last_char <= cur_last;
		end
	end

	assign busy      = busy_q;
	assign chr_valid = out_valid_q;
	assign chr       = out_q;

endmodule

// ===== src/signed_int_to_decimal_ascii_unit.sv =====
// Signed integer to decimal ASCII formatter.
// arg channel (arg_valid/arg_ready/arg): one request holds a 16-bit signed
// number, a field width (-1 = strip leading zeros), 0 to 2 decimal places and
// a force-plus flag. chr channel (chr_valid/chr_ready/chr): one request per
// ASCII character: optional sign, integer digits, optional '.' and fraction
// digits; last_char marks the final character of the number.
// Timing: the magnitude goes through a shift-add-3 converter, one bit per
// cycle. Its BCD result is loaded into the emitter, which offers the first
// character from its output register, then one character per cycle while
// chr_ready is high. A request yields N characters, at most 7.
// A request that yields no character returns the block to idle with no output.
// arg_ready is high only while no request is being converted or emitted; the
// last character may still sit in the output register when the next request
// is taken. When chr_ready is low the output register holds its character and
// emission pauses. Reset (arst_n, asynchronous) drops all work in flight and
// clears chr_valid.
module signed_int_to_decimal_ascii_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 arg_valid,
	output logic                 arg_ready,
	input  sitdc_pkg::arg_req_t  arg,
	output logic                 chr_valid,
	input  logic                 chr_ready,
	output sitdc_pkg::chr_req_t  chr
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                     state_q;
	sitdc_pkg::fmt_t                fmt_q;
	logic                           accept;
	logic [sitdc_pkg::BIN_BITS-1:0] mag;
	logic                           conv_done;
	logic [sitdc_pkg::BCD_BITS-1:0] bcd;
	logic                           emit_busy;

	assign arg_ready = state_q == ST_IDLE;
	assign accept    = arg_valid && arg_ready;
	assign mag       = arg.number[15] ? ~arg.number + 16'd1 : arg.number;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept)     state_q <= ST_CONV;
				ST_CONV: if (conv_done)  state_q <= ST_EMIT;
				ST_EMIT: if (!emit_busy) state_q <= ST_IDLE;
				default:                 state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fmt_q.negative       <= arg.number[15];
			fmt_q.force_plus     <= arg.force_plus;
			fmt_q.field_width    <= arg.field_width;
			fmt_q.decimal_places <= arg.decimal_places;
		end
	end

	sitdc_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.done   (conv_done),
		.bcd    (bcd)
	);

	sitdc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (conv_done),
		.fmt       (fmt_q),
		.bcd       (bcd),
		.busy      (emit_busy),
		.chr_valid (chr_valid),
		.chr_ready (chr_ready),
		.chr       (chr)
	);

endmodule
